// ----- hw/rtl/ludpp_pkg.sv -----
// Shared types and constants for the LU decomposition unit.
// No dependencies; the top level, front end, divider and back end import this package.
`default_nettype none

package ludpp_pkg;

  localparam int DEF_MAX_ORDER  = 8;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int ELEM_W    = 32;
  localparam int SRC_W     = 3;
  localparam int SWAP_W    = 3;
  localparam int ORDER_W   = 4;
  localparam int THRESH_W  = 16;
  localparam int FRAC_BITS = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ORDER       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGULAR_THRESHOLD = 1'd1;

  localparam logic [ORDER_W-1:0]  ORDER_RESET  = 4'd8;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1;

  // Widest store address over the supported orders.
  localparam int CMD_AW      = 6;
  localparam int QUEUE_DEPTH = 2;

  // One classified load beat handed from the front end to the back end.
  typedef struct packed {
    logic [ELEM_W-1:0]  value;
    logic [CMD_AW-1:0]  addr;
    logic               wr;
    logic               first;
    logic               clamp;
    logic               last;
    logic [ORDER_W-1:0] order;
  } cmd_t;

  function automatic int val_bits(input int dw);
    return (dw < 32) ? dw : 32;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ludpp_if.sv -----
// Valid/ready stream interfaces for matrix elements and results.
// Depends on nothing; used by the top level, the front end and the back end.
`default_nettype none

interface ludpp_elem_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] elem_value;
  logic               elem_last;

  modport source (output valid, elem_value, elem_last, input ready);
  modport sink   (input valid, elem_value, elem_last, output ready);
endinterface

interface ludpp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lu_value;
  logic [2:0]         source_row;
  logic [2:0]         swap_count;
  logic               singular;
  logic               saturated;
  logic               result_last;

  modport source (output valid, lu_value, source_row, swap_count, singular, saturated,
                  result_last, input ready);
  modport sink   (input valid, lu_value, source_row, swap_count, singular, saturated,
                  result_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lu_decompose_partial_pivot_unit.sv -----
// Loads take one beat per cycle while the queue has room and the back end is idle;
// after the last beat the elimination runs column by column: a pivot search, a row
// swap where needed, the multipliers on the serial divider and a trailing-block update.
// Results then leave one beat at a time; one matrix is worked on at a time.
// Reset is synchronous and active high; it clears control state and configuration
// but not the element store, whose entries are undefined until loaded.
`default_nettype none

// LU decomposition with partial row pivoting on a Q16.16 square matrix.
// Depends on ludpp_pkg, ludpp_if, ludpp_queue, ludpp_front and ludpp_back.
//
// The front end accepts element beats, clamps each value to the stored width,
// assigns its column-major store address and flags the first and last beats of
// a load. A two-entry queue hands those commands to the back end, so a load keeps
// streaming while the back end writes the store. The back end owns the element
// memory, the row-origin registers, the swap count and the clamp flag. After the
// last beat it searches each column for the largest magnitude, swaps rows,
// checks the pivot against the threshold, divides out the multipliers on a
// serial divider and updates the trailing block one element at a time through
// the store's single read port. The packed result is then read out column by column
// into an output register, which lets the back end move on while a beat waits.

module lu_decompose_partial_pivot_unit
  import ludpp_pkg::*;
#(
  parameter int MAX_ORDER  = DEF_MAX_ORDER,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  ludpp_elem_if.sink                 elem,
  ludpp_result_if.source             result
);

  logic [ORDER_W-1:0]  matrix_order;
  logic [THRESH_W-1:0] singular_threshold;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // Configuration registers; they are meant to be written only while no matrix
  // is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_order       <= ORDER_RESET;
      singular_threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MATRIX_ORDER:       matrix_order       <= cfg_data[ORDER_W-1:0];
        REG_SINGULAR_THRESHOLD: singular_threshold <= cfg_data[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ludpp_front #(.MAX_ORDER(MAX_ORDER), .DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .elem         (elem),
    .matrix_order (matrix_order),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  ludpp_queue #(.WIDTH($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .empty     (q_empty)
  );

  ludpp_back #(.MAX_ORDER(MAX_ORDER), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (!q_empty),
    .q_cmd              (pop_cmd),
    .q_pop              (q_pop),
    .singular_threshold (singular_threshold),
    .result             (result)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ludpp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ludpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ludpp_queue.sv -----
// Small FIFO that decouples the load front end from the back end.
// No dependencies.
`default_nettype none

module ludpp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ludpp_front.sv -----
// Load front end: accepts element beats, clamps them and assigns store addresses.
// Depends on ludpp_pkg and the element stream interface.
`default_nettype none

module ludpp_front
  import ludpp_pkg::*;
#(
  parameter int MAX_ORDER  = DEF_MAX_ORDER,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  ludpp_elem_if.sink              elem,
  input  wire logic [ORDER_W-1:0] matrix_order,
  input  wire logic               q_full,
  output logic                    q_push,
  output cmd_t                    q_cmd
);

  localparam int VB = val_bits(DATA_WIDTH);
  localparam int NW = $clog2(MAX_ORDER + 1);
  localparam int LW = $clog2(MAX_ORDER * MAX_ORDER + 1);

  localparam logic [ELEM_W-1:0] VAL_HI = {{(ELEM_W - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
  localparam logic [ELEM_W-1:0] VAL_LO = {{(ELEM_W - VB + 1){1'b1}}, {(VB - 1){1'b0}}};

  logic [LW-1:0] load_index;
  logic [NW-1:0] n_use;
  logic [LW-1:0] n_sq;
  logic          in_range;
  logic          store_ok;

  always_comb begin
    if (matrix_order == '0) begin
      n_use = NW'(1);
    end else if (matrix_order > ORDER_W'(MAX_ORDER)) begin
      n_use = NW'(MAX_ORDER);
    end else begin
      n_use = NW'(matrix_order);
    end
  end

  assign n_sq     = LW'(n_use) * LW'(n_use);
  assign store_ok = (load_index < n_sq);
  // In range when every bit above the sign of the stored width agrees.
  assign in_range = (&elem.elem_value[ELEM_W-1:VB-1]) || !(|elem.elem_value[ELEM_W-1:VB-1]);

  assign elem.ready = !q_full;
  assign q_push     = elem.valid && !q_full;

  always_comb begin
    q_cmd.value = in_range ? elem.elem_value : (elem.elem_value[ELEM_W-1] ? VAL_LO : VAL_HI);
    q_cmd.addr  = CMD_AW'(load_index);
    q_cmd.wr    = store_ok;
    q_cmd.first = (load_index == '0);
    q_cmd.clamp = !in_range;
    q_cmd.last  = elem.elem_last;
    q_cmd.order = ORDER_W'(n_use);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
    end else if (q_push) begin
      if (elem.elem_last) begin
        load_index <= '0;
      end else if (store_ok) begin
        load_index <= load_index + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ludpp_div.sv -----
// Radix-2 restoring divider for the multipliers: (num * 2^16) / den, saturated.
// Depends on ludpp_pkg.
`default_nettype none

module ludpp_div
  import ludpp_pkg::*;
#(
  parameter int VB = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [VB-1:0] num,
  input  wire logic signed [VB-1:0] den,
  output logic                      done,
  output logic signed [VB-1:0]      quo,
  output logic                      sat
);

  localparam int QW = VB + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);
  localparam logic [QW-1:0] QPOS = {{(QW - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
  localparam logic [QW-1:0] QNEG = QPOS + 1'b1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [QW-1:0] num_sh;
  logic [QW-1:0] q_mag;
  logic [VB-1:0] rem;
  logic [VB-1:0] den_mag;
  logic          neg;
  logic [VB:0]   rem_sh;
  logic          ge;
  logic [VB-1:0] num_mag;
  logic [VB:0]   rem_diff;

  assign num_mag  = num[VB-1] ? (~num + 1'b1) : num;
  assign rem_sh   = {rem, num_sh[QW-1]};
  assign ge       = (rem_sh >= {1'b0, den_mag});
  assign rem_diff = rem_sh - {1'b0, den_mag};

  always_comb begin
    if (neg) begin
      sat = (q_mag > QNEG);
      quo = sat ? {1'b1, {(VB - 1){1'b0}}} : (~q_mag[VB-1:0] + 1'b1);
    end else begin
      sat = (q_mag > QPOS);
      quo = sat ? {1'b0, {(VB - 1){1'b1}}} : q_mag[VB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh  <= {num_mag, {FRAC_BITS{1'b0}}};
      den_mag <= den[VB-1] ? (~den + 1'b1) : den;
      neg     <= num[VB-1] ^ den[VB-1];
      rem     <= '0;
      q_mag   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[QW-2:0], 1'b0};
      rem    <= ge ? rem_diff[VB-1:0] : rem_sh[VB-1:0];
      q_mag  <= {q_mag[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ludpp_back.sv -----
// Back end: stores loaded elements, runs the pivoted elimination, emits results.
// Depends on ludpp_pkg, ludpp_ram, ludpp_div and the result stream interface.
`default_nettype none

module ludpp_back
  import ludpp_pkg::*;
#(
  parameter int MAX_ORDER  = DEF_MAX_ORDER,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  cmd_t                     q_cmd,
  output logic                     q_pop,
  input  wire logic [THRESH_W-1:0] singular_threshold,
  ludpp_result_if.source           result
);

  localparam int VB    = val_bits(DATA_WIDTH);
  localparam int IW    = $clog2(MAX_ORDER);
  localparam int NW    = $clog2(MAX_ORDER + 1);
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * VB;
  localparam int SW    = PW - FRAC_BITS;
  localparam int CPW   = (VB > THRESH_W) ? VB : THRESH_W;

  localparam logic signed [SW-1:0] SHI = {{(SW - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
  localparam logic signed [SW-1:0] SLO = {{(SW - VB + 1){1'b1}}, {(VB - 1){1'b0}}};
  localparam logic signed [VB-1:0] VHI = {1'b0, {(VB - 1){1'b1}}};
  localparam logic signed [VB-1:0] VLO = {1'b1, {(VB - 1){1'b0}}};

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] S_SRCH_RD  = 5'd1;
  localparam logic [ST_W-1:0] S_SRCH_CMP = 5'd2;
  localparam logic [ST_W-1:0] S_PIVOT    = 5'd3;
  localparam logic [ST_W-1:0] S_SW_RDA   = 5'd4;
  localparam logic [ST_W-1:0] S_SW_RDB   = 5'd5;
  localparam logic [ST_W-1:0] S_SW_WR1   = 5'd6;
  localparam logic [ST_W-1:0] S_SW_WR2   = 5'd7;
  localparam logic [ST_W-1:0] S_OSW1     = 5'd8;
  localparam logic [ST_W-1:0] S_OSW2     = 5'd9;
  localparam logic [ST_W-1:0] S_OSW3     = 5'd10;
  localparam logic [ST_W-1:0] S_CHECK    = 5'd11;
  localparam logic [ST_W-1:0] S_L_RD     = 5'd12;
  localparam logic [ST_W-1:0] S_L_DIV    = 5'd13;
  localparam logic [ST_W-1:0] S_L_WAIT   = 5'd14;
  localparam logic [ST_W-1:0] S_U_RD     = 5'd15;
  localparam logic [ST_W-1:0] S_A_RD     = 5'd16;
  localparam logic [ST_W-1:0] S_MUL      = 5'd17;
  localparam logic [ST_W-1:0] S_UPD      = 5'd18;
  localparam logic [ST_W-1:0] S_WR       = 5'd19;
  localparam logic [ST_W-1:0] S_SING     = 5'd20;
  localparam logic [ST_W-1:0] S_O_RD     = 5'd21;
  localparam logic [ST_W-1:0] S_O_PUSH   = 5'd22;

  logic [ST_W-1:0] state;
  logic [NW-1:0]   n_run;
  logic [IW-1:0]   k;
  logic [IW-1:0]   i;
  logic [IW-1:0]   j;
  logic [IW-1:0]   pick;
  logic [IW-1:0]   last_idx;
  logic [VB-1:0]   best;
  logic signed [VB-1:0] best_val;
  logic signed [VB-1:0] t_a;
  logic signed [VB-1:0] l_val;
  logic signed [VB-1:0] u_val;
  logic signed [VB-1:0] a_val;
  logic signed [VB-1:0] pc;
  logic signed [PW-1:0] prod;
  logic [IW-1:0]   origin [MAX_ORDER];
  logic [IW-1:0]   o_tmp;
  logic [IW-1:0]   orig_sel;
  logic [IW-1:0]   orig_rd;
  logic [SWAP_W-1:0] swaps;
  logic            sat;

  logic            out_valid;
  logic signed [ELEM_W-1:0] out_lu;
  logic [SRC_W-1:0]  out_src;
  logic [SWAP_W-1:0] out_swap;
  logic            out_sing;
  logic            out_sat;
  logic            out_last;
  logic            slot_free;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic signed [VB-1:0] rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [VB-1:0]   wr_data;

  logic            div_start;
  logic            div_done;
  logic signed [VB-1:0] div_quo;
  logic            div_sat;

  logic [VB-1:0]   rd_mag;
  logic signed [PW-1:0] prod_adj;
  logic signed [SW-1:0] prod_q;
  logic signed [VB:0]   diff;
  logic            diff_ovf;
  logic signed [VB-1:0] diff_sat;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] col,
                                              input logic [IW-1:0] row,
                                              input logic [NW-1:0] n);
    return AW'(col) * AW'(n) + AW'(row);
  endfunction

  ludpp_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ludpp_div #(.VB(VB)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rd_data),
    .den   (best_val),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  assign last_idx  = IW'(n_run - 1'b1);
  assign rd_mag    = rd_data[VB-1] ? (~rd_data + 1'b1) : rd_data;
  assign orig_rd   = origin[orig_sel];
  assign slot_free = !out_valid || result.ready;
  assign q_pop     = (state == S_IDLE) && q_valid;

  // Truncate the product toward zero before dropping the fraction bits.
  assign prod_adj = prod + $signed({{(PW - FRAC_BITS){1'b0}}, {FRAC_BITS{prod[PW-1]}}});
  assign prod_q   = SW'(prod_adj >>> FRAC_BITS);
  assign diff     = {a_val[VB-1], a_val} - {pc[VB-1], pc};
  assign diff_ovf = diff[VB] != diff[VB-1];
  assign diff_sat = diff_ovf ? (diff[VB] ? VLO : VHI) : diff[VB-1:0];

  assign result.valid       = out_valid;
  assign result.lu_value    = out_lu;
  assign result.source_row  = out_src;
  assign result.swap_count  = out_swap;
  assign result.singular    = out_sing;
  assign result.saturated   = out_sat;
  assign result.result_last = out_last;

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    div_start = 1'b0;
    orig_sel  = k;
    unique case (state)
      S_IDLE: begin
        if (q_valid && q_cmd.wr) begin
          wr_en   = 1'b1;
          wr_addr = AW'(q_cmd.addr);
          wr_data = q_cmd.value[VB-1:0];
        end
      end
      S_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = cell_addr(k, i, n_run);
      end
      S_SW_RDA: begin
        rd_en   = 1'b1;
        rd_addr = cell_addr(j, k, n_run);
      end
      S_SW_RDB: begin
        rd_en   = 1'b1;
        rd_addr = cell_addr(j, pick, n_run);
      end
      S_SW_WR1: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(j, k, n_run);
        wr_data = rd_data;
      end
      S_SW_WR2: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(j, pick, n_run);
        wr_data = t_a;
      end
      S_OSW2: begin
        orig_sel = pick;
      end
      S_L_RD: begin
        rd_en   = 1'b1;
        rd_addr = cell_addr(k, i, n_run);
      end
      S_L_DIV: begin
        div_start = 1'b1;
      end
      S_L_WAIT: begin
        if (div_done) begin
          wr_en   = 1'b1;
          wr_addr = cell_addr(k, i, n_run);
          wr_data = div_quo;
        end
      end
      S_U_RD: begin
        rd_en   = 1'b1;
        rd_addr = cell_addr(j, k, n_run);
      end
      S_A_RD: begin
        rd_en   = 1'b1;
        rd_addr = cell_addr(j, i, n_run);
      end
      S_WR: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(j, i, n_run);
        wr_data = diff_sat;
      end
      S_O_RD: begin
        rd_en   = 1'b1;
        rd_addr = cell_addr(j, i, n_run);
      end
      S_O_PUSH: begin
        orig_sel = i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      swaps     <= '0;
      sat       <= 1'b0;
      for (int e = 0; e < MAX_ORDER; e++) begin
        origin[e] <= IW'(e);
      end
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.first) begin
              for (int e = 0; e < MAX_ORDER; e++) begin
                origin[e] <= IW'(e);
              end
              swaps <= '0;
              sat   <= q_cmd.clamp;
            end else begin
              sat <= sat | q_cmd.clamp;
            end
            if (q_cmd.last) begin
              n_run <= NW'(q_cmd.order);
              k     <= '0;
              i     <= '0;
              j     <= '0;
              state <= (q_cmd.order > ORDER_W'(1)) ? S_SRCH_RD : S_O_RD;
            end
          end
        end
        S_SRCH_RD: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          // The diagonal seeds the search; later rows win only when strictly larger.
          if (i == k || best < rd_mag) begin
            best     <= rd_mag;
            best_val <= rd_data;
            pick     <= i;
          end
          if (i == last_idx) begin
            state <= S_PIVOT;
          end else begin
            i     <= i + 1'b1;
            state <= S_SRCH_RD;
          end
        end
        S_PIVOT: begin
          j     <= '0;
          state <= (pick != k) ? S_SW_RDA : S_CHECK;
        end
        S_SW_RDA: begin
          state <= S_SW_RDB;
        end
        S_SW_RDB: begin
          t_a   <= rd_data;
          state <= S_SW_WR1;
        end
        S_SW_WR1: begin
          state <= S_SW_WR2;
        end
        S_SW_WR2: begin
          if (j == last_idx) begin
            state <= S_OSW1;
          end else begin
            j     <= j + 1'b1;
            state <= S_SW_RDA;
          end
        end
        S_OSW1: begin
          o_tmp <= orig_rd;
          state <= S_OSW2;
        end
        S_OSW2: begin
          origin[k] <= orig_rd;
          state     <= S_OSW3;
        end
        S_OSW3: begin
          origin[pick] <= o_tmp;
          swaps        <= swaps + 1'b1;
          state        <= S_CHECK;
        end
        S_CHECK: begin
          if (best_val == '0 || CPW'(best) < CPW'(singular_threshold)) begin
            state <= S_SING;
          end else begin
            i     <= k + 1'b1;
            state <= S_L_RD;
          end
        end
        S_L_RD: begin
          state <= S_L_DIV;
        end
        S_L_DIV: begin
          state <= S_L_WAIT;
        end
        S_L_WAIT: begin
          if (div_done) begin
            l_val <= div_quo;
            sat   <= sat | div_sat;
            j     <= k + 1'b1;
            state <= S_U_RD;
          end
        end
        S_U_RD: begin
          state <= S_A_RD;
        end
        S_A_RD: begin
          u_val <= rd_data;
          state <= S_MUL;
        end
        S_MUL: begin
          a_val <= rd_data;
          prod  <= l_val * u_val;
          state <= S_UPD;
        end
        S_UPD: begin
          if (prod_q > SHI) begin
            pc  <= VHI;
            sat <= 1'b1;
          end else if (prod_q < SLO) begin
            pc  <= VLO;
            sat <= 1'b1;
          end else begin
            pc <= prod_q[VB-1:0];
          end
          state <= S_WR;
        end
        S_WR: begin
          if (diff_ovf) begin
            sat <= 1'b1;
          end
          if (j != last_idx) begin
            j     <= j + 1'b1;
            state <= S_U_RD;
          end else if (i != last_idx) begin
            i     <= i + 1'b1;
            state <= S_L_RD;
          end else if (NW'(k) + NW'(2) >= n_run) begin
            i     <= '0;
            j     <= '0;
            state <= S_O_RD;
          end else begin
            k     <= k + 1'b1;
            i     <= k + 1'b1;
            state <= S_SRCH_RD;
          end
        end
        S_SING: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_lu    <= '0;
            out_src   <= '0;
            out_swap  <= swaps;
            out_sing  <= 1'b1;
            out_sat   <= sat;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_O_RD: begin
          state <= S_O_PUSH;
        end
        S_O_PUSH: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_lu    <= ELEM_W'(rd_data);
            out_src   <= SRC_W'(orig_rd);
            out_swap  <= swaps;
            out_sing  <= 1'b0;
            out_sat   <= sat;
            out_last  <= (i == last_idx) && (j == last_idx);
            if (i == last_idx) begin
              i <= '0;
              if (j == last_idx) begin
                state <= S_IDLE;
              end else begin
                j     <= j + 1'b1;
                state <= S_O_RD;
              end
            end else begin
              i     <= i + 1'b1;
              state <= S_O_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ludpp_checker.sv -----
// Port-level checks for the LU decomposition unit, bound to the top level.
// Depends on nothing but the top level's port signals.
`default_nettype none

module ludpp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] res_lu_value,
  input wire logic [2:0]  res_source_row,
  input wire logic        res_singular,
  input wire logic        res_last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_lu_value) && $stable(res_last))
    else $error("result beat changed while stalled");

  a_singular_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_singular |-> res_last && res_lu_value == 32'd0 && res_source_row == 3'd0)
    else $error("singular beat is not a lone zero final beat");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind lu_decompose_partial_pivot_unit ludpp_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_lu_value   (result.lu_value),
  .res_source_row (result.source_row),
  .res_singular   (result.singular),
  .res_last       (result.result_last)
);

`default_nettype wire
